// File: rtl/tsm_pkg.sv
// Package for the tachometer speed meter: payload structs, widths, constants,
// register indexes and the controller state type. No dependencies.
`default_nettype none

package tsm_pkg;

  localparam int INTERVAL_BITS = 24;
  localparam int COUNT_BITS    = 16;
  localparam int PPR_BITS      = 4;
  localparam int RPM_BITS      = 16;

  localparam int PROD_BITS  = INTERVAL_BITS + COUNT_BITS;
  localparam int ACC_BITS   = PROD_BITS + 1;
  localparam int DEN_BITS   = INTERVAL_BITS + PPR_BITS;
  localparam int REM_BITS   = DEN_BITS;
  localparam int QUOT_BITS  = 26;
  localparam int STEP_BITS  = 5;

  localparam logic [QUOT_BITS-1:0] RPM_DIVIDEND = QUOT_BITS'(60000000);
  localparam logic [STEP_BITS-1:0] UPD_STEPS    = STEP_BITS'(INTERVAL_BITS);
  localparam logic [STEP_BITS-1:0] SPD_STEPS    = STEP_BITS'(QUOT_BITS);

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  typedef struct packed {
    logic                     cmd;
    logic [INTERVAL_BITS-1:0] interval_us;
    logic                     stretch_active;
  } tsm_in_t;

  typedef struct packed {
    logic [RPM_BITS-1:0]      speed_rpm;
    logic                     speed_valid;
    logic [INTERVAL_BITS-1:0] average_us;
    logic [COUNT_BITS-1:0]    edge_count;
  } tsm_out_t;

  typedef enum logic {
    CMD_EDGE    = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MIN_INTERVAL   = 2'd0,
    REG_MAX_INTERVAL   = 2'd1,
    REG_PULSES_PER_REV = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/tacho_speed_meter_top.sv
// Tachometer speed meter, top level: APB registers, controller and output register.
// Depends on tsm_pkg, tsm_mul and tsm_div.
//
// One transaction is taken at a time. An edge that is ignored, rejected or
// arrives with an empty window, and a compute command with a zero average or
// zero pulses per revolution, skips the multiplier and divider and goes
// straight to the done state. An edge that updates the average takes 16
// multiplier steps for avg*(n-1), then 24 divider steps to divide that plus
// the new interval by n. A speed computation takes 16 multiplier steps for
// ppr*avg and 26 divider steps for 60000000/den. A finished result waits in
// the output register while the next transaction is taken in.
`default_nettype none

module tacho_speed_meter_top
  import tsm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire tsm_in_t                  in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output tsm_out_t                      out_data
);

  logic [INTERVAL_BITS-1:0] min_interval;
  logic [INTERVAL_BITS-1:0] max_interval;
  logic [PPR_BITS-1:0]      ppr;
  cfg_reg_t                 reg_sel;
  logic                     cfg_write;

  state_t state, state_next;

  logic [INTERVAL_BITS-1:0] avg, avg_next;
  logic [COUNT_BITS-1:0]    count, count_next;
  logic                     cmd_q, active_q, upd_q, spd_q;
  logic [INTERVAL_BITS-1:0] interval_q;

  logic accept, upd, spd, mul_start, div_start, load;
  logic [RPM_BITS-1:0] speed;
  logic                speed_ok;

  logic [INTERVAL_BITS-1:0]  mul_a;
  logic [COUNT_BITS-1:0]     mul_b;
  logic [PROD_BITS-1:0]      product;
  logic                      mul_done;
  logic [ACC_BITS-1:0]       acc;
  logic [STEP_BITS-1:0]      div_steps;
  logic [REM_BITS-1:0]       div_hi;
  logic [QUOT_BITS-1:0]      div_lo;
  logic [DEN_BITS-1:0]       div_d;
  logic [QUOT_BITS-1:0]      quotient;
  logic                      div_done;

  assign pready    = 1'b1;
  assign reg_sel   = cfg_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= '0;
      max_interval <= '1;
      ppr          <= PPR_BITS'(2);
    end else if (cfg_write) begin
      case (reg_sel)
        REG_MIN_INTERVAL:   min_interval <= pwdata[INTERVAL_BITS-1:0];
        REG_MAX_INTERVAL:   max_interval <= pwdata[INTERVAL_BITS-1:0];
        REG_PULSES_PER_REV: ppr          <= pwdata[PPR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_INTERVAL:   prdata = APB_DATA_BITS'(min_interval);
      REG_MAX_INTERVAL:   prdata = APB_DATA_BITS'(max_interval);
      REG_PULSES_PER_REV: prdata = APB_DATA_BITS'(ppr);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    upd = (in_data.cmd == CMD_EDGE) && in_data.stretch_active &&
          (in_data.interval_us > min_interval) && (in_data.interval_us < max_interval) &&
          (count != '0);
    spd = (in_data.cmd == CMD_COMPUTE) && (avg != '0) && (ppr != '0);
    if (in_data.cmd == CMD_EDGE) begin
      mul_b = count - 1'b1;
    end else begin
      mul_b = {{(COUNT_BITS-PPR_BITS){1'b0}}, ppr};
    end
    mul_a = avg;
  end

  always_comb begin
    acc = {1'b0, product} + ACC_BITS'(interval_q);
    if (cmd_q == CMD_EDGE) begin
      div_steps = UPD_STEPS;
      div_hi    = REM_BITS'(acc[ACC_BITS-1:INTERVAL_BITS]);
      div_lo    = {acc[INTERVAL_BITS-1:0], {(QUOT_BITS-INTERVAL_BITS){1'b0}}};
      div_d     = DEN_BITS'(count);
    end else begin
      div_steps = SPD_STEPS;
      div_hi    = '0;
      div_lo    = RPM_DIVIDEND;
      div_d     = product[DEN_BITS-1:0];
    end
  end

  tsm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (product),
    .done    (mul_done)
  );

  tsm_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .steps       (div_steps),
    .dividend_hi (div_hi),
    .dividend_lo (div_lo),
    .divisor     (div_d),
    .quotient    (quotient),
    .done        (div_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = (upd || spd) ? ST_MUL : ST_DONE;
      ST_MUL:  if (mul_done) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_DONE;
      ST_DONE: if (load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    accept    = in_valid && !in_stall;
    mul_start = accept && (upd || spd);
    div_start = (state == ST_MUL) && mul_done;
    load      = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= in_data.cmd;
      active_q   <= in_data.stretch_active;
      interval_q <= in_data.interval_us;
      upd_q      <= upd;
      spd_q      <= spd;
    end
  end

  always_comb begin
    speed    = '0;
    speed_ok = 1'b0;
    if (cmd_q == CMD_EDGE) begin
      avg_next   = upd_q ? quotient[INTERVAL_BITS-1:0] : avg;
      count_next = (active_q && (count != '1)) ? count + 1'b1 : count;
    end else begin
      avg_next   = '0;
      count_next = '0;
      speed_ok   = (avg != '0);
      if (spd_q) begin
        speed = (quotient[QUOT_BITS-1:RPM_BITS] != '0) ? '1 : quotient[RPM_BITS-1:0];
      end else if (speed_ok) begin
        speed = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        avg       <= avg_next;
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.speed_rpm   <= speed;
      out_data.speed_valid <= speed_ok;
      out_data.average_us  <= avg_next;
      out_data.edge_count  <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside its state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside its state");

  a_empty_window: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> avg == '0)
    else $error("nonzero average with an empty window");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && state == ST_IDLE)
    else $error("result load did not reach the output register");
`endif

endmodule

`default_nettype wire

// File: rtl/tsm_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on tsm_pkg for operand widths.
`default_nettype none

module tsm_mul
  import tsm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [INTERVAL_BITS-1:0] a,
  input  wire logic [COUNT_BITS-1:0]    b,
  output logic [PROD_BITS-1:0]          product,
  output logic                          done
);

  localparam logic [STEP_BITS-1:0] MUL_STEPS = STEP_BITS'(COUNT_BITS);

  logic [INTERVAL_BITS-1:0] a_q;
  logic [INTERVAL_BITS-1:0] hi;
  logic [COUNT_BITS-1:0]    lo;
  logic [STEP_BITS-1:0]     cnt;
  logic [INTERVAL_BITS:0]   sum;

  always_comb begin
    sum = {1'b0, hi} + (lo[0] ? {1'b0, a_q} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= MUL_STEPS;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      hi  <= '0;
      lo  <= b;
    end else if (cnt != '0) begin
      hi <= sum[INTERVAL_BITS:1];
      lo <= {sum[0], lo[COUNT_BITS-1:1]};
    end
  end

  assign product = {hi, lo};

endmodule

`default_nettype wire

// File: rtl/tsm_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tsm_pkg for operand widths.
`default_nettype none

module tsm_div
  import tsm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [STEP_BITS-1:0] steps,
  input  wire logic [REM_BITS-1:0]  dividend_hi,
  input  wire logic [QUOT_BITS-1:0] dividend_lo,
  input  wire logic [DEN_BITS-1:0]  divisor,
  output logic [QUOT_BITS-1:0]      quotient,
  output logic                      done
);

  logic [DEN_BITS-1:0]  d_q;
  logic [REM_BITS-1:0]  rem;
  logic [QUOT_BITS-1:0] q;
  logic [STEP_BITS-1:0] cnt;
  logic [REM_BITS:0]    trial;
  logic [REM_BITS:0]    diff;
  logic                 ge;

  always_comb begin
    trial = {rem, q[QUOT_BITS-1]};
    diff  = trial - {1'b0, d_q};
    ge    = trial >= {1'b0, d_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= steps;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_q <= divisor;
      rem <= dividend_hi;
      q   <= dividend_lo;
    end else if (cnt != '0) begin
      rem <= ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
      q   <= {q[QUOT_BITS-2:0], ge};
    end
  end

  assign quotient = q;

endmodule

`default_nettype wire
